@@ hdl/cpew_pkg.sv @@
// shared constants for the weighted cyclic-prefix energy window sum
package cpew_pkg;

    // default geometry
    localparam int DEF_WINDOW      = 16;
    localparam int DEF_SAMPLE_BITS = 12;
    localparam int DEF_RHO_BITS    = 16;

    // fixed port widths
    localparam int CFG_W = 16;
    localparam int OUT_W = 27;

endpackage

@@ hdl/cpew_cell.sv @@
// one delay-line cell holding a single weighted energy
module cpew_cell #(
    parameter int E_W = 23
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  logic [E_W-1:0] i_energy,
    output logic [E_W-1:0] o_energy
);

    logic [E_W-1:0] r_energy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy <= '0;
        end else if (i_shift) begin
            r_energy <= i_energy;
        end
    end

    assign o_energy = r_energy;

endmodule

@@ hdl/cpew_energy.sv @@
// four-stage pipeline computing (rho * sum of squares) >> (rho bits + 1)
module cpew_energy
    import cpew_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int RHO_BITS    = DEF_RHO_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_cur_real,
    input  logic signed [SAMPLE_BITS-1:0] i_cur_imag,
    input  logic signed [SAMPLE_BITS-1:0] i_lag_real,
    input  logic signed [SAMPLE_BITS-1:0] i_lag_imag,
    input  logic [RHO_BITS-1:0]           i_rho,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2*SAMPLE_BITS-2:0]      o_energy
);

    localparam int SQ_W = 2 * SAMPLE_BITS - 1;
    localparam int S_W  = 2 * SAMPLE_BITS + 1;
    localparam int H    = (S_W + 1) / 2;
    localparam int HI_W = S_W - H;
    localparam int LO_P = RHO_BITS + H;
    localparam int HI_P = RHO_BITS + HI_W;
    localparam int P_W  = RHO_BITS + S_W;
    localparam int E_W  = 2 * SAMPLE_BITS - 1;

    logic r_va, r_vb, r_vc, r_vd;
    logic rdy_a, rdy_b, rdy_c, rdy_d;

    logic [SQ_W-1:0] r_sq_cr, r_sq_ci, r_sq_lr, r_sq_li;
    logic [S_W-1:0]  r_sum;
    logic [LO_P-1:0] r_plo;
    logic [HI_P-1:0] r_phi;
    logic [E_W-1:0]  r_energy;

    logic signed [2*SAMPLE_BITS-1:0] sq_cr, sq_ci, sq_lr, sq_li;
    logic [P_W-1:0] prod;

    // stage moves when empty or when the next one moves
    assign rdy_d   = !r_vd || i_ready;
    assign rdy_c   = !r_vc || rdy_d;
    assign rdy_b   = !r_vb || rdy_c;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;

    assign sq_cr = i_cur_real * i_cur_real;
    assign sq_ci = i_cur_imag * i_cur_imag;
    assign sq_lr = i_lag_real * i_lag_real;
    assign sq_li = i_lag_imag * i_lag_imag;

    assign prod = (P_W'(r_phi) << H) + P_W'(r_plo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (rdy_a) r_va <= i_valid;
            if (rdy_b) r_vb <= r_va;
            if (rdy_c) r_vc <= r_vb;
            if (rdy_d) r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_sq_cr <= sq_cr[SQ_W-1:0];
            r_sq_ci <= sq_ci[SQ_W-1:0];
            r_sq_lr <= sq_lr[SQ_W-1:0];
            r_sq_li <= sq_li[SQ_W-1:0];
        end
        if (rdy_b && r_va) begin
            r_sum <= S_W'(r_sq_cr) + S_W'(r_sq_ci) + S_W'(r_sq_lr) + S_W'(r_sq_li);
        end
        // split product keeps each multiplier narrow
        if (rdy_c && r_vb) begin
            r_plo <= LO_P'(i_rho) * LO_P'(r_sum[H-1:0]);
            r_phi <= HI_P'(i_rho) * HI_P'(r_sum[S_W-1:H]);
        end
        if (rdy_d && r_vc) begin
            r_energy <= prod[RHO_BITS+1 +: E_W];
        end
    end

    assign o_valid  = r_vd;
    assign o_energy = r_energy;

endmodule

@@ hdl/cp_energy_window_sum_core.sv @@
// top level: weighted energy moving sum over a chain of delay cells
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  input    | i_valid / o_ready  | i_cur_real, i_cur_imag, i_lag_real, i_lag_imag
//  output   | o_valid / i_ready  | o_window_energy
//  config   | i_cfg_wr_en        | i_cfg_wr_data (rho, unsigned q0.16)
//
// one item per cycle sustained while the result side keeps reading; the accepting
// edge loads the first of four energy stages, and o_valid rises when the item
// reaches the output register, the last step
// the delay cells and running total update when an item loads the output
// register, so the window moves once per item
// synchronous active-low reset clears rho, the cells, the total and all valids
// a held result stalls only the stages behind it; bubbles still fill
module cp_energy_window_sum_core
    import cpew_pkg::*;
#(
    parameter int WINDOW      = DEF_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int RHO_BITS    = DEF_RHO_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_W-1:0]              i_cfg_wr_data,
    // input items
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_cur_real,
    input  logic signed [SAMPLE_BITS-1:0] i_cur_imag,
    input  logic signed [SAMPLE_BITS-1:0] i_lag_real,
    input  logic signed [SAMPLE_BITS-1:0] i_lag_imag,
    // result items
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [OUT_W-1:0]              o_window_energy
);

    localparam int E_W   = 2 * SAMPLE_BITS - 1;
    localparam int TOT_W = E_W + $clog2(WINDOW);
    localparam int SAT_W = (TOT_W > OUT_W) ? TOT_W : OUT_W;

    logic [CFG_W-1:0] r_rho_q16;

    logic           e_valid;
    logic           e_ready;
    logic [E_W-1:0] e_energy;

    logic [E_W-1:0] cell_q [WINDOW];

    logic             out_free;
    logic             take;
    logic [TOT_W-1:0] r_total;
    logic [TOT_W-1:0] n_total;
    logic [SAT_W-1:0] total_x;
    logic [OUT_W-1:0] n_window_energy;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_window_energy;

    // rho register, written only while idle by the user; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rho_q16 <= '0;
        end else if (i_cfg_wr_en) begin
            r_rho_q16 <= i_cfg_wr_data;
        end
    end

    cpew_energy #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .RHO_BITS    (RHO_BITS)
    ) u_energy (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_cur_real (i_cur_real),
        .i_cur_imag (i_cur_imag),
        .i_lag_real (i_lag_real),
        .i_lag_imag (i_lag_imag),
        .i_rho      (RHO_BITS'(r_rho_q16)),
        .o_valid    (e_valid),
        .i_ready    (e_ready),
        .o_energy   (e_energy)
    );

    // output register frees up when empty or being read
    assign out_free = !r_out_valid || i_ready;
    assign e_ready  = out_free;
    assign take     = e_valid && out_free;

    // delay line: newest energy enters cell 0, oldest leaves the last cell
    genvar g;
    generate
        for (g = 0; g < WINDOW; g++) begin : g_cell
            if (g == 0) begin : g_head
                cpew_cell #(.E_W(E_W)) u_cell (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_shift  (take),
                    .i_energy (e_energy),
                    .o_energy (cell_q[g])
                );
            end else begin : g_body
                cpew_cell #(.E_W(E_W)) u_cell (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_shift  (take),
                    .i_energy (cell_q[g-1]),
                    .o_energy (cell_q[g])
                );
            end
        end
    endgenerate

    // running total: add newest, drop the one leaving the window
    assign n_total = r_total + TOT_W'(e_energy) - TOT_W'(cell_q[WINDOW-1]);

    // saturate to the output width, only reachable with wide parameters
    assign total_x = SAT_W'(n_total);
    assign n_window_energy = (total_x > SAT_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}}
                                                                 : total_x[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_total     <= n_total;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_window_energy <= n_window_energy;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_window_energy = r_window_energy;

endmodule

@@ hdl/cpew_checker.sv @@
// port-level checks for the energy window sum, bound to the top level
module cpew_checker
    import cpew_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic [OUT_W-1:0] o_window_energy
);

    // a result held back keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_window_energy)))
        else $error("result changed while stalled");

    // with the output free, every pipeline stage can move
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input stalled while output side free");

    // reset empties the pipe; no result sooner than the pipeline depth
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n, 1)) |-> !o_valid)
        else $error("result present right after reset");

    a_reset_latency: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n, 5)) |-> !o_valid)
        else $error("result faster than pipeline latency after reset");

endmodule

bind cp_energy_window_sum_core cpew_checker u_cpew_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_window_energy (o_window_energy)
);

@@ tb/cp_energy_window_sum_core_tb.sv @@
// self-checking testbench for the weighted cyclic-prefix energy window sum
`timescale 1ns / 1ps

module cp_energy_window_sum_core_tb;
    import cpew_pkg::*;

    // sample and energy geometry at the default parameters
    typedef logic signed [DEF_SAMPLE_BITS-1:0] sample_t;

    localparam int ENERGY_W    = 2 * DEF_SAMPLE_BITS - 1;
    localparam int SCALE_SHIFT = DEF_RHO_BITS + 1;
    localparam int SAMPLE_MIN  = -(1 << (DEF_SAMPLE_BITS - 1));
    localparam int SAMPLE_MAX  = (1 << (DEF_SAMPLE_BITS - 1)) - 1;
    localparam logic [31:0] OUT_MAX = (32'd1 << OUT_W) - 1;

    // run control
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int MAX_GAP      = 40;
    localparam int PHASE_ITEMS  = 150;
    localparam int PRINT_LIMIT  = 100;

    // directed stimulus row: rho to use, sample pair, optional typed result
    typedef struct packed {
        logic [CFG_W-1:0] rho;
        sample_t          cur_re;
        sample_t          cur_im;
        sample_t          lag_re;
        sample_t          lag_im;
        logic             typed;
        logic [OUT_W-1:0] typed_energy;
    } sample_row_t;

    // dut ports, all inputs known from time zero
    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] i_cfg_wr_data = '0;
    logic             i_valid       = 1'b0;
    logic             o_ready;
    sample_t          i_cur_real    = '0;
    sample_t          i_cur_imag    = '0;
    sample_t          i_lag_real    = '0;
    sample_t          i_lag_imag    = '0;
    logic             o_valid;
    logic             i_ready       = 1'b0;
    logic [OUT_W-1:0] o_window_energy;

    // predictor state: its own copy of rho, the delay line and the total
    logic [CFG_W-1:0]    rho_w;
    logic [ENERGY_W-1:0] energy_hist [DEF_WINDOW];
    logic [31:0]         window_total;
    int                  hist_pos;

    // expected window sums, oldest first
    logic [OUT_W-1:0] energy_expect_q [$];
    logic [OUT_W-1:0] expected_energy;

    sample_row_t sample_rows [$];

    // idling knobs, percent per cycle
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // long receiver hold-off: main toggles hold_arm, receiver counts it down
    logic hold_arm  = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    int mismatches  = 0;
    int cycle_count = 0;

    cp_energy_window_sum_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cur_real      (i_cur_real),
        .i_cur_imag      (i_cur_imag),
        .i_lag_real      (i_lag_real),
        .i_lag_imag      (i_lag_imag),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_window_energy (o_window_energy)
    );

    // 20 ns clock
    always #10 i_clk = ~i_clk;

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // one line per mismatch, printing capped but always counted
    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] want,
                                   input logic [OUT_W-1:0] got);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s, expected %0d got %0d",
                     cycle_count, what, want, got);
        mismatches++;
    endtask

    // exact square, the most negative sample included
    function automatic logic [ENERGY_W-1:0] square_of(input sample_t v);
        int m;
        m = v;
        return ENERGY_W'(m * m);
    endfunction

    // weighted energy of one sample pair pushed through the 16-deep window
    task automatic predict_window_energy(input sample_t cr, input sample_t ci,
                                         input sample_t lr, input sample_t li,
                                         output logic [OUT_W-1:0] sum_out);
        logic [ENERGY_W+1:0] sq_sum;
        logic [63:0]         weighted;
        logic [ENERGY_W-1:0] item_energy;
        sq_sum      = square_of(cr) + square_of(ci) + square_of(lr) + square_of(li);
        weighted    = rho_w * sq_sum;
        // the shift folds in the factor one half, floor on the low bits
        item_energy = ENERGY_W'(weighted >> SCALE_SHIFT);
        window_total = window_total + item_energy - energy_hist[hist_pos];
        energy_hist[hist_pos] = item_energy;
        hist_pos = (hist_pos + 1) % DEF_WINDOW;
        sum_out = (window_total > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : window_total[OUT_W-1:0];
    endtask

    // offer one item after a random gap, hold it until accepted, then
    // record the expected window sum
    task automatic send_sample(input sample_t cr, input sample_t ci,
                               input sample_t lr, input sample_t li,
                               input logic typed, input logic [OUT_W-1:0] typed_energy);
        int               gap;
        logic [OUT_W-1:0] predicted;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cur_real <= cr;
        i_cur_imag <= ci;
        i_lag_real <= lr;
        i_lag_imag <= li;
        do @(posedge i_clk); while (!o_ready);
        predict_window_energy(cr, ci, lr, li, predicted);
        energy_expect_q.push_back(typed ? typed_energy : predicted);
    endtask

    // stop offering and wait until every result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (energy_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    // rho is only written with the pipeline empty
    task automatic write_rho(input logic [CFG_W-1:0] value);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        rho_w = value;
    endtask

    task automatic add_row(input logic [CFG_W-1:0] rho, input int cr, input int ci,
                           input int lr, input int li, input logic typed,
                           input int typed_energy);
        sample_row_t row;
        row.rho          = rho;
        row.cur_re       = sample_t'(cr);
        row.cur_im       = sample_t'(ci);
        row.lag_re       = sample_t'(lr);
        row.lag_im       = sample_t'(li);
        row.typed        = typed;
        row.typed_energy = typed_energy[OUT_W-1:0];
        sample_rows.push_back(row);
    endtask

    // sample mix: rails, zero, small values and full-range noise
    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0: return sample_t'(SAMPLE_MIN);
            1: return sample_t'(SAMPLE_MAX);
            2: return '0;
            3: return sample_t'(int'($urandom_range(0, 15)) - 8);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // one random phase: new rho, idling mode, optional long hold-off
    task automatic run_phase(input logic [CFG_W-1:0] rho, input int send_pct,
                             input int recv_pct, input logic hold);
        write_rho(rho);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (hold)
            hold_arm <= ~hold_arm;
        repeat (PHASE_ITEMS)
            send_sample(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                        1'b0, '0);
    endtask

    // receiver: random stalls, or a long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_arm != hold_seen) begin
            hold_seen <= hold_arm;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // result checker: every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (energy_expect_q.size() == 0) begin
                report_mismatch("result with nothing expected", '0, o_window_energy);
            end else begin
                expected_energy = energy_expect_q.pop_front();
                if (o_window_energy != expected_energy)
                    report_mismatch("window_energy", expected_energy, o_window_energy);
            end
        end
    end

    initial begin
        // predictor matches the reset state
        rho_w        = '0;
        window_total = '0;
        hist_pos     = 0;
        for (int k = 0; k < DEF_WINDOW; k++)
            energy_hist[k] = '0;

        // rho still at its reset value of zero: every energy is zero
        add_row(16'd0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b1, 0);
        add_row(16'd0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 0);
        add_row(16'd0, SAMPLE_MIN, SAMPLE_MAX, -1, 0, 1'b1, 0);
        // full rho, most negative samples on all four parts, window still filling
        add_row(16'hFFFF, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b1, 8388480);
        add_row(16'hFFFF, 0, 0, 0, 0, 1'b1, 8388480);
        add_row(16'hFFFF, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0, 0);
        // one rail at a time, then unit values and mixed rails
        add_row(16'hFFFF, SAMPLE_MIN, 0, 0, 0, 1'b0, 0);
        add_row(16'hFFFF, 0, SAMPLE_MIN, 0, 0, 1'b0, 0);
        add_row(16'hFFFF, 0, 0, SAMPLE_MIN, 0, 1'b0, 0);
        add_row(16'hFFFF, 0, 0, 0, SAMPLE_MIN, 1'b0, 0);
        add_row(16'hFFFF, 1, -1, 1, -1, 1'b0, 0);
        add_row(16'hFFFF, -1, -1, -1, -1, 1'b0, 0);
        add_row(16'hFFFF, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b0, 0);
        // alternating bit patterns
        add_row(16'hFFFF, 1365, -1366, 1365, -1366, 1'b0, 0);
        // smallest nonzero rho: energies collapse to a few lsbs
        add_row(16'd1, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0, 0);
        add_row(16'd1, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0, 0);
        add_row(16'd1, 3, -3, 5, -5, 1'b0, 0);
        // half weight, the window wraps and old entries start leaving
        add_row(16'h8000, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0, 0);
        add_row(16'h8000, 100, -200, 300, -400, 1'b0, 0);
        add_row(16'h8000, SAMPLE_MAX, 0, SAMPLE_MIN, 0, 1'b0, 0);

        // reset held from time zero, released once
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, back to back
        foreach (sample_rows[r]) begin
            if (sample_rows[r].rho != rho_w)
                write_rho(sample_rows[r].rho);
            send_sample(sample_rows[r].cur_re, sample_rows[r].cur_im,
                        sample_rows[r].lag_re, sample_rows[r].lag_im,
                        sample_rows[r].typed, sample_rows[r].typed_energy);
        end

        // random part: rho extremes and random values across idling modes
        run_phase(16'hFFFF, 0, 0, 1'b0);
        run_phase(16'($urandom), 53, 0, 1'b0);
        run_phase(16'd0, 0, 53, 1'b0);
        run_phase(16'd1, 35, 35, 1'b0);
        // receiver holds off while the sender keeps offering
        run_phase(16'hFFFF, 0, 0, 1'b1);
        run_phase(16'($urandom), 53, 0, 1'b0);
        run_phase(16'h8000, 0, 53, 1'b0);
        run_phase(16'($urandom), 35, 35, 1'b0);

        // let the pipeline empty, then watch for stray results
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
